### rtl/core/assert_macros.svh
// assertion macros for the rtl of the freshness filter
// no dependencies; callers provide clk and arst_n in scope

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SFF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SFF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/sff_pkg.sv
// shared types and defaults for the sequence freshness filter
// no dependencies

package sff_pkg;

	// default sizes of the connection table and the missed window
	localparam int CONNECTIONS_DEF = 16;
	localparam int MISS_WINDOW_DEF = 64;

	// field widths fixed by the packet format
	localparam int KIND_W = 2;
	localparam int SLOT_W_IN = 4;
	localparam int SEQ_W = 16;

	// request kinds carried in tuser
	typedef enum logic [KIND_W-1:0] {
		REQ_SYNC     = 2'd0,
		REQ_RELIABLE = 2'd1,
		REQ_STREAM   = 2'd2,
		REQ_ACK      = 2'd3
	} req_kind_t;

	// request held in the input stage
	typedef struct packed {
		req_kind_t              kind;
		logic                   slot_ok;
		logic [SLOT_W_IN-1:0]   slot;
		logic [SEQ_W-1:0]       seq;
	} req_stage_t;

endpackage

### rtl/core/seq_freshness_filter.sv
// top level of the sequence freshness filter: per-slot state memory and decision logic
// depends on sff_pkg and assert_macros.svh
//
//  channel  | dir | tdata                              | tuser
//  s_axis   | in  | conn_slot[3:0], seq_num[19:4]      | req_type[1:0]
//  m_axis   | out | deliver[0], send_ack[1]            | -
//
// one request per cycle unless stalled; its result is registered after the input stage
// state memory read at acceptance, written as the input stage advances, a write to the
// slot being read in the same cycle is forwarded into the read register
// after reset a clearing pass writes zeros over CONNECTIONS entries, one per cycle,
// with s_axis_tready low throughout
// a stalled result holds the input stage, and no state is written until it moves on

`include "assert_macros.svh"

module seq_freshness_filter #(
	parameter int CONNECTIONS = sff_pkg::CONNECTIONS_DEF,
	parameter int MISS_WINDOW = sff_pkg::MISS_WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // conn_slot[3:0], seq_num[19:4], zero pad
	input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // deliver[0], send_ack[1], zero pad
);

	localparam int SLOT_W = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
	localparam int SH_W   = $clog2(MISS_WINDOW);
	localparam int SEQ_W  = sff_pkg::SEQ_W;
	localparam int ENT_W  = 2 * SEQ_W + MISS_WINDOW;

	// state memory, entry: reliable last, stream last, missed map from the lowest bit up
	logic [ENT_W-1:0] state_mem [CONNECTIONS];

	logic                 clearing_q;
	logic [SLOT_W-1:0]    clr_cnt_q;
	sff_pkg::req_stage_t  req_s1;
	logic                 req_valid_s1;
	logic [ENT_W-1:0]     rd_q;
	logic                 out_valid_q;
	logic                 deliver_q;
	logic                 send_ack_q;

	logic                 s_fire;
	logic                 s1_adv;
	logic                 in_slot_ok;
	logic [SLOT_W-1:0]    rd_addr;
	logic [SLOT_W-1:0]    wr_addr;
	logic [ENT_W-1:0]     wr_data;
	logic                 mem_we;
	logic                 fwd_hit;
	logic                 data_kind;

	logic [SEQ_W-1:0]       rel_last;
	logic [SEQ_W-1:0]       str_last;
	logic [MISS_WINDOW-1:0] miss_map;
	logic [SEQ_W-1:0]       d_rel;
	logic [SEQ_W-1:0]       d_rel_m1;
	logic [SEQ_W-1:0]       d_str;
	logic [SEQ_W-1:0]       k_back;
	logic [SEQ_W-1:0]       k_bit;
	logic                   rel_newer;
	logic                   str_newer;
	logic                   miss_hit;
	logic [MISS_WINDOW-1:0] shifted_map;
	logic [MISS_WINDOW-1:0] gap_ones;
	logic [SEQ_W-1:0]       new_rel;
	logic [SEQ_W-1:0]       new_str;
	logic [MISS_WINDOW-1:0] new_map;
	logic                   res_deliver;
	logic                   res_ack;
	logic                   res_write;

	// handshakes
	assign s1_adv        = req_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !clearing_q && (!req_valid_s1 || s1_adv);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign in_slot_ok    = 32'(s_axis_tdata[3:0]) < CONNECTIONS;
	assign rd_addr       = in_slot_ok ? SLOT_W'(s_axis_tdata[3:0]) : '0;

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == SLOT_W'(CONNECTIONS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (s_fire) begin
			req_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			req_valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (s_fire) begin
			req_s1.kind    <= sff_pkg::req_kind_t'(s_axis_tuser);
			req_s1.slot_ok <= in_slot_ok;
			req_s1.slot    <= s_axis_tdata[3:0];
			req_s1.seq     <= s_axis_tdata[19:4];
		end
	end

	// memory write port, shared by the clearing pass and the update
	assign mem_we  = clearing_q || (s1_adv && res_write);
	assign wr_addr = clearing_q ? clr_cnt_q : SLOT_W'(req_s1.slot);
	assign fwd_hit = mem_we && (wr_addr == rd_addr);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			state_mem[wr_addr] <= clearing_q ? '0 : wr_data;
		end
	end

	// registered read with forwarding of a same-cycle write
	always_ff @(posedge clk) begin
		if (s_fire) begin
			if (fwd_hit) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= state_mem[rd_addr];
			end
		end
	end

	// unpack the slot state
	assign rel_last = rd_q[SEQ_W-1:0];
	assign str_last = rd_q[2*SEQ_W-1:SEQ_W];
	assign miss_map = rd_q[ENT_W-1:2*SEQ_W];

	// cyclic distances
	assign d_rel     = req_s1.seq - rel_last;
	assign d_rel_m1  = d_rel - 1'b1;
	assign d_str     = req_s1.seq - str_last;
	assign rel_newer = (d_rel != '0) && !d_rel[SEQ_W-1];
	assign str_newer = (d_str != '0) && !d_str[SEQ_W-1];
	assign k_back    = rel_last - req_s1.seq;
	assign k_bit     = k_back - 1'b1;

	// window advance: shift old marks up, mark the skipped numbers
	always_comb begin
		if (d_rel < SEQ_W'(MISS_WINDOW)) begin
			shifted_map = miss_map << SH_W'(d_rel);
		end else begin
			shifted_map = '0;
		end
		if (d_rel_m1 < SEQ_W'(MISS_WINDOW)) begin
			gap_ones = ~({MISS_WINDOW{1'b1}} << SH_W'(d_rel_m1));
		end else begin
			gap_ones = '1;
		end
	end

	// late arrival of a number still marked missed
	assign miss_hit = (k_back != '0) && (k_bit < SEQ_W'(MISS_WINDOW))
		&& miss_map[SH_W'(k_bit)];

	// decision and next slot state
	always_comb begin
		new_rel     = rel_last;
		new_str     = str_last;
		new_map     = miss_map;
		res_deliver = 1'b0;
		res_ack     = 1'b0;
		res_write   = 1'b0;
		if (req_s1.slot_ok) begin
			case (req_s1.kind)
				sff_pkg::REQ_SYNC: begin
					new_rel   = '0;
					new_str   = '0;
					new_map   = '0;
					res_ack   = 1'b1;
					res_write = 1'b1;
				end
				sff_pkg::REQ_RELIABLE: begin
					res_ack = 1'b1;
					if (rel_newer) begin
						new_rel     = req_s1.seq;
						new_map     = shifted_map | gap_ones;
						res_deliver = 1'b1;
						res_write   = 1'b1;
					end else if (miss_hit) begin
						new_map[SH_W'(k_bit)] = 1'b0;
						res_deliver = 1'b1;
						res_write   = 1'b1;
					end
				end
				sff_pkg::REQ_STREAM: begin
					if (str_newer) begin
						new_str     = req_s1.seq;
						res_deliver = 1'b1;
						res_write   = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign wr_data = {new_map, new_str, new_rel};

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			deliver_q  <= res_deliver;
			send_ack_q <= res_ack;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, send_ack_q, deliver_q};

	// checks
	assign data_kind = (req_s1.kind == sff_pkg::REQ_RELIABLE)
		|| (req_s1.kind == sff_pkg::REQ_STREAM);

	`SFF_ASSERT(a_fwd_read, (s_fire && fwd_hit) |=> (rd_q == $past(wr_data)), "forwarded read lost")
	`SFF_ASSERT(a_write_on_move, (mem_we && !clearing_q) |-> s1_adv, "write without a moving request")
	`SFF_ASSERT(a_deliver_kind, (req_valid_s1 && res_deliver) |-> data_kind, "control request delivered")
	`SFF_ASSERT_ALWAYS(a_no_take_in_clear, clearing_q |-> !s_fire, "request taken during clearing")

endmodule

### test/sff_freshness_check.sv
`timescale 1ns / 100ps
// checker for the sequence freshness filter: watches both stream channels, predicts each verdict
// and compares it with what the block returns; depends on sff_pkg

module sff_freshness_check #(
	parameter int CONNECTIONS = sff_pkg::CONNECTIONS_DEF,
	parameter int MISS_WINDOW = sff_pkg::MISS_WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // conn_slot[3:0], seq_num[19:4], zero pad
	input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,   // deliver[0], send_ack[1], zero pad
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic deliver;
		logic send_ack;
	} filter_verdict_t;

	// own copy of the per-slot sequence state
	logic [15:0] rel_last  [CONNECTIONS];
	logic [15:0] strm_last [CONNECTIONS];
	logic [63:0] gap_map   [CONNECTIONS];

	filter_verdict_t verdict_q [$];
	filter_verdict_t seen;
	filter_verdict_t want;
	int faults;

	function automatic logic [63:0] low_mask(input int unsigned n);
		if (n >= 64)
			return '1;
		return (64'd1 << n) - 64'd1;
	endfunction

	// cyclic comparison: a is ahead of b by 1..32767
	function automatic logic is_ahead(input logic [15:0] a, input logic [15:0] b);
		logic [15:0] d;
		d = a - b;
		return (d >= 16'd1) && (d <= 16'd32767);
	endfunction

	// decide one request and update the slot state
	function automatic filter_verdict_t judge_packet(input sff_pkg::req_kind_t kind,
			input logic [3:0] slot, input logic [15:0] seq);
		filter_verdict_t v;
		logic [15:0] delta;
		logic [63:0] map;
		int unsigned pos;
		v = '0;
		if (slot < CONNECTIONS) begin
			case (kind)
				sff_pkg::REQ_SYNC: begin
					rel_last[slot] = '0;
					strm_last[slot] = '0;
					gap_map[slot] = '0;
					v.send_ack = 1'b1;
				end
				sff_pkg::REQ_RELIABLE: begin
					v.send_ack = 1'b1;
					if (is_ahead(seq, rel_last[slot])) begin
						delta = seq - rel_last[slot];
						map = (delta >= 16'd64) ? 64'd0 : (gap_map[slot] << delta);
						map |= low_mask(delta - 1);
						gap_map[slot] = map & low_mask(MISS_WINDOW);
						rel_last[slot] = seq;
						v.deliver = 1'b1;
					end else if (seq != rel_last[slot]) begin
						// late packet: deliver once if still marked missed
						delta = rel_last[slot] - seq;
						pos = delta - 1;
						if (pos < MISS_WINDOW && gap_map[slot][pos]) begin
							gap_map[slot][pos] = 1'b0;
							v.deliver = 1'b1;
						end
					end
				end
				sff_pkg::REQ_STREAM: begin
					if (is_ahead(seq, strm_last[slot])) begin
						strm_last[slot] = seq;
						v.deliver = 1'b1;
					end
				end
				default: ;
			endcase
		end
		return v;
	endfunction

	task automatic log_fault(input string what, input filter_verdict_t exp_v,
			input filter_verdict_t got_v);
		faults++;
		if (faults <= 10)
			$display("%0t: %s: expected deliver=%0b send_ack=%0b, got deliver=%0b send_ack=%0b",
				$time, what, exp_v.deliver, exp_v.send_ack, got_v.deliver, got_v.send_ack);
	endtask

	// compare results first, then log the new request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CONNECTIONS; i++) begin
				rel_last[i] = '0;
				strm_last[i] = '0;
				gap_map[i] = '0;
			end
			verdict_q.delete();
			faults = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen.deliver = m_axis_tdata[0];
				seen.send_ack = m_axis_tdata[1];
				if (verdict_q.size() == 0) begin
					log_fault("result with none outstanding", '0, seen);
				end else begin
					want = verdict_q.pop_front();
					if (seen.deliver !== want.deliver || seen.send_ack !== want.send_ack)
						log_fault("wrong result", want, seen);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				verdict_q.push_back(judge_packet(sff_pkg::req_kind_t'(s_axis_tuser),
					s_axis_tdata[3:0], s_axis_tdata[19:4]));
			pending <= verdict_q.size();
			fail_count <= faults;
		end
	end

endmodule

### test/tb_seq_freshness_filter.sv
`timescale 1ns / 100ps
// testbench top for the sequence freshness filter: clock, reset, request stimulus and verdict
// depends on sff_pkg, seq_freshness_filter and sff_freshness_check

module tb_seq_freshness_filter;

	localparam int RANDOM_ITEMS = 880;
	localparam int CALM_TAIL = 120;
	localparam int LONG_HOLD = 200;
	localparam int DRAIN = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;   // conn_slot[3:0], seq_num[19:4], zero pad
	logic [1:0]  s_axis_tuser = '0;   // req_type[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // deliver[0], send_ack[1], zero pad

	int fail_count;
	int pending;
	bit calm = 1'b0;
	bit long_hold_req = 1'b0;

	// per-slot cursors steering the well-formed sequences
	logic [15:0] rel_cur  [16];
	logic [15:0] strm_cur [16];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	seq_freshness_filter DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	sff_freshness_check checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// offer one request, with an occasional idle burst ahead of it
	task automatic offer_request(input sff_pkg::req_kind_t kind, input logic [3:0] slot,
			input logic [15:0] seq);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {4'b0, seq, slot};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		while (!arst_n)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		int pick;
		int r;
		int jump;
		logic [3:0] slot;
		logic [15:0] seq;
		sff_pkg::req_kind_t kind;

		for (int i = 0; i < 16; i++) begin
			rel_cur[i] = '0;
			strm_cur[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reliable ordering, gaps, late arrivals and window edge on slot 0
		offer_request(sff_pkg::REQ_SYNC, 4'd0, 16'h1234);
		offer_request(sff_pkg::REQ_RELIABLE, 4'd0, 16'd1);
		offer_request(sff_pkg::REQ_RELIABLE, 4'd0, 16'd1);
		offer_request(sff_pkg::REQ_RELIABLE, 4'd0, 16'd5);
		offer_request(sff_pkg::REQ_RELIABLE, 4'd0, 16'd3);
		offer_request(sff_pkg::REQ_RELIABLE, 4'd0, 16'd3);
		offer_request(sff_pkg::REQ_RELIABLE, 4'd0, 16'd32773);
		offer_request(sff_pkg::REQ_RELIABLE, 4'd0, 16'd100);
		offer_request(sff_pkg::REQ_RELIABLE, 4'd0, 16'd36);
		offer_request(sff_pkg::REQ_RELIABLE, 4'd0, 16'd35);
		offer_request(sff_pkg::REQ_RELIABLE, 4'd0, 16'd99);
		// stream freshness, equal and half-range numbers
		offer_request(sff_pkg::REQ_STREAM, 4'd0, 16'd0);
		offer_request(sff_pkg::REQ_STREAM, 4'd0, 16'hFFFF);
		offer_request(sff_pkg::REQ_STREAM, 4'd0, 16'd32767);
		offer_request(sff_pkg::REQ_STREAM, 4'd0, 16'hFFFF);
		offer_request(sff_pkg::REQ_ACK, 4'd0, 16'hFFFF);
		// top slot and extreme numbers
		offer_request(sff_pkg::REQ_SYNC, 4'd15, 16'hABCD);
		offer_request(sff_pkg::REQ_RELIABLE, 4'd15, 16'hFFFF);
		offer_request(sff_pkg::REQ_RELIABLE, 4'd15, 16'd32767);
		offer_request(sff_pkg::REQ_RELIABLE, 4'd15, 16'd32768);
		offer_request(sff_pkg::REQ_STREAM, 4'd15, 16'h8000);
		offer_request(sff_pkg::REQ_ACK, 4'd15, 16'd0);
		offer_request(sff_pkg::REQ_RELIABLE, 4'd9, 16'hFFFF);

		// random part: mostly well-formed sequences on a few busy slots
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= RANDOM_ITEMS - CALM_TAIL);
			if (i == 300)
				long_hold_req = 1'b1;
			pick = $urandom_range(0, 99);
			slot = 4'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 3)
				: $urandom_range(0, 15));
			seq = 16'($urandom_range(0, 65535));
			if (pick < 12) begin
				kind = sff_pkg::req_kind_t'(2'($urandom_range(0, 3)));
			end else if (pick < 16) begin
				kind = sff_pkg::REQ_SYNC;
				rel_cur[slot] = '0;
				strm_cur[slot] = '0;
			end else if (pick < 20) begin
				kind = sff_pkg::REQ_ACK;
			end else if (pick < 70) begin
				kind = sff_pkg::REQ_RELIABLE;
				r = $urandom_range(0, 9);
				if (r < 6) begin
					rel_cur[slot] = rel_cur[slot] + 16'($urandom_range(1, 4));
					seq = rel_cur[slot];
				end else if (r < 9) begin
					// late or repeated packet
					seq = rel_cur[slot] - 16'($urandom_range(0, 70));
				end else begin
					jump = ($urandom_range(0, 3) == 0) ? $urandom_range(32760, 32775)
						: $urandom_range(5, 100);
					seq = rel_cur[slot] + 16'(jump);
					if (jump < 32768)
						rel_cur[slot] = seq;
				end
			end else begin
				kind = sff_pkg::REQ_STREAM;
				if ($urandom_range(0, 9) < 7) begin
					strm_cur[slot] = strm_cur[slot] + 16'($urandom_range(1, 3));
					seq = strm_cur[slot];
				end else begin
					seq = strm_cur[slot] - 16'($urandom_range(0, 5));
				end
			end
			offer_request(kind, slot, seq);
		end
		s_axis_tvalid <= 1'b0;

		// drain outstanding results
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// hard limit on run length
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
